FILE: rtl/pfba_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pfba_pkg;

    localparam int MAX_PAGES_DEF = 32768;
    localparam int PAGE_SHIFT    = 12;

    // request kinds
    localparam logic [1:0] FN_ALLOC       = 2'd0;
    localparam logic [1:0] FN_ALLOC_UPPER = 2'd1;
    localparam logic [1:0] FN_FREE        = 2'd2;

    // result status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_FULL       = 3'd1;
    localparam logic [2:0] ST_MISALIGNED = 3'd2;
    localparam logic [2:0] ST_NOT_ALLOC  = 3'd3;
    localparam logic [2:0] ST_RANGE      = 3'd4;

    // configuration register indexes
    localparam logic [1:0] REG_BASE_PAGE   = 2'd0;
    localparam logic [1:0] REG_PAGE_COUNT  = 2'd1;
    localparam logic [1:0] REG_UPPER_START = 2'd2;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_FREE_CHK,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [19:0] base_page;
        logic [15:0] page_count;
        logic [10:0] upper_start_word;
    } cfg_t;

    typedef struct packed {
        logic [31:0] page_addr;
        logic [2:0]  status;
    } res_t;

endpackage

`default_nettype wire

FILE: rtl/pfba_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module pfba_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [31:0]   wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output logic      [31:0]   rdata
);

    logic [31:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/pfba_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module pfba_ctrl
    import pfba_pkg::*;
#(
    parameter int MAX_PAGES = MAX_PAGES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire cfg_t        cfg,
    input  wire logic        req_valid,
    output logic             req_ready,
    input  wire logic [1:0]  req_func,
    input  wire logic [31:0] req_addr,
    output logic             res_valid,
    input  wire logic        res_ready,
    output res_t             res
);

    localparam int WORDS = (MAX_PAGES + 31) / 32;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int LIMW  = $clog2(MAX_PAGES + 1);
    localparam int CW    = (LIMW > 20) ? LIMW : 20;
    localparam int WCW   = $clog2(WORDS + 1);
    localparam int RW    = (WCW > 11) ? WCW : 11;
    localparam int KW    = (RW + 5 > CW) ? RW + 5 : CW;

    state_t state_reg, state_next;

    logic [AW-1:0] clr_reg, clr_next;
    logic [RW-1:0] rd_w_reg, rd_w_next;
    logic [AW-1:0] chk_w_reg, chk_w_next;
    logic          chk_valid_reg, chk_valid_next;
    logic [AW-1:0] fw_reg, fw_next;
    logic [4:0]    fbit_reg, fbit_next;
    logic          mis_reg, mis_next;
    logic [31:0]   res_addr_reg, res_addr_next;
    logic [2:0]    res_status_reg, res_status_next;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [31:0]   mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic [31:0]   mem_rdata;

    logic [CW-1:0] lim;
    logic          accept;
    logic          more;
    logic [KW-1:0] rem;
    logic [31:0]   mask;
    logic [31:0]   free_bits;
    logic          found;
    logic [4:0]    fidx;
    logic [19:0]   pg;
    logic [19:0]   idx;
    logic          out_of_range;
    logic [19:0]   alloc_page;

    pfba_mem #(
        .DEPTH (WORDS),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign lim = (CW'(cfg.page_count) > CW'(MAX_PAGES)) ? CW'(MAX_PAGES)
                                                        : CW'(cfg.page_count);

    assign req_ready = (state_reg == S_IDLE);
    assign accept    = req_valid && req_ready;
    assign res_valid = (state_reg == S_DONE);
    assign res       = '{page_addr: res_addr_reg, status: res_status_reg};

    // scan: word still inside the managed range
    assign more = KW'({rd_w_reg, 5'b0}) < KW'(lim);
    assign rem  = KW'(lim) - KW'({chk_w_reg, 5'b0});
    assign mask = (rem >= KW'(32)) ? 32'hFFFF_FFFF
                                   : ((32'd1 << rem[4:0]) - 32'd1);
    assign free_bits = ~mem_rdata & mask;
    assign found     = |free_bits;

    always_comb
    begin
        fidx = 5'd0;
        for (int i = 31; i >= 0; i--)
        begin
            if (free_bits[i])
            begin
                fidx = 5'(i);
            end
        end
    end

    assign alloc_page = cfg.base_page + 20'({chk_w_reg, fidx});

    // free request decode
    assign pg           = req_addr[31:PAGE_SHIFT];
    assign idx          = pg - cfg.base_page;
    assign out_of_range = (pg < cfg.base_page) || (CW'(idx) >= lim);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_reg == AW'(WORDS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    case (req_func)
                        FN_ALLOC, FN_ALLOC_UPPER: state_next = S_SCAN;
                        FN_FREE:  state_next = out_of_range ? S_DONE : S_FREE_CHK;
                        default:  state_next = S_DONE;
                    endcase
                end
            end
            S_SCAN:
            begin
                if ((chk_valid_reg && found) || (!chk_valid_reg && !more))
                begin
                    state_next = S_DONE;
                end
            end
            S_FREE_CHK:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        clr_next        = clr_reg;
        rd_w_next       = rd_w_reg;
        chk_w_next      = chk_w_reg;
        chk_valid_next  = 1'b0;
        fw_next         = fw_reg;
        fbit_next       = fbit_reg;
        mis_next        = mis_reg;
        res_addr_next   = res_addr_reg;
        res_status_next = res_status_reg;
        mem_we          = 1'b0;
        mem_waddr       = chk_w_reg;
        mem_wdata       = mem_rdata;
        mem_re          = 1'b0;
        mem_raddr       = rd_w_reg[AW-1:0];

        case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = 32'd0;
                clr_next  = clr_reg + AW'(1);
            end
            S_IDLE:
            begin
                res_addr_next   = 32'd0;
                res_status_next = ST_OK;
                rd_w_next       = (req_func == FN_ALLOC_UPPER) ? RW'(cfg.upper_start_word)
                                                               : RW'(0);
                fw_next         = idx[AW+4:5];
                fbit_next       = idx[4:0];
                mis_next        = |req_addr[PAGE_SHIFT-1:0];
                if (accept && (req_func == FN_FREE))
                begin
                    if (out_of_range)
                    begin
                        res_status_next = ST_RANGE;
                    end
                    else
                    begin
                        mem_re    = 1'b1;
                        mem_raddr = idx[AW+4:5];
                    end
                end
            end
            S_SCAN:
            begin
                if (chk_valid_reg && found)
                begin
                    mem_we        = 1'b1;
                    mem_waddr     = chk_w_reg;
                    mem_wdata     = mem_rdata | (32'd1 << fidx);
                    res_addr_next = {alloc_page, 12'd0};
                end
                else
                begin
                    if (more)
                    begin
                        mem_re         = 1'b1;
                        chk_valid_next = 1'b1;
                        chk_w_next     = rd_w_reg[AW-1:0];
                        rd_w_next      = rd_w_reg + RW'(1);
                    end
                    else if (!chk_valid_reg)
                    begin
                        res_status_next = ST_FULL;
                    end
                end
            end
            S_FREE_CHK:
            begin
                if (mem_rdata[fbit_reg])
                begin
                    mem_we          = 1'b1;
                    mem_waddr       = fw_reg;
                    mem_wdata       = mem_rdata & ~(32'd1 << fbit_reg);
                    res_status_next = mis_reg ? ST_MISALIGNED : ST_OK;
                end
                else
                begin
                    res_status_next = ST_NOT_ALLOC;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            chk_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            chk_valid_reg <= chk_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_w_reg       <= rd_w_next;
        chk_w_reg      <= chk_w_next;
        fw_reg         <= fw_next;
        fbit_reg       <= fbit_next;
        mis_reg        <= mis_next;
        res_addr_reg   <= res_addr_next;
        res_status_reg <= res_status_next;
    end

    a_no_rw_same_word: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && mem_re && (mem_waddr == mem_raddr)))
        else $error("bitmap read and write hit the same word");

    a_no_req_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !req_ready)
        else $error("request taken during clearing pass");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && mem_re) |-> (KW'({rd_w_reg, 5'b0}) < KW'(lim)))
        else $error("scan read beyond frame limit");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != S_IDLE))
        else $error("accepted request produced no work");

    a_check_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FREE_CHK) |-> $past(mem_re))
        else $error("free check without bitmap read");

endmodule

`default_nettype wire

FILE: rtl/page_frame_bitmap_allocator.sv
`timescale 1ns / 1ps
`default_nettype none

// Page frame allocator with one used bit per 4 KiB frame, held in a
// MAX_PAGES/32 x 32 bit synchronous RAM. After reset a clearing pass writes
// zero to every bitmap word, one word per cycle (MAX_PAGES/32 words, 1024 by
// default); no request is taken until it ends, config writes are taken at any
// time. A free request reads the bitmap word of its frame and clears the
// frame's bit if it is set; a frame outside the region and a no-operation word
// go straight to the result. An alloc request reads the bitmap one word per
// cycle from its start word (0, or upper_start_word for alloc upper) up to the
// first word with a free frame in range and sets that bit; with no free frame
// it ends after reading all words left in range, or without reading any word
// when its start word lies past the last frame.
// One request is in work at a time; the result register lets the next request
// in while a result waits. Write configuration only while the block is idle.
module page_frame_bitmap_allocator
    import pfba_pkg::*;
#(
    parameter int MAX_PAGES = MAX_PAGES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [19:0] cfg_data,

    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // frame_addr[31:0]
    input  wire logic [1:0]  s_axis_tuser,   // func[1:0]

    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // page_addr[31:0]
    output logic [2:0]       m_axis_tuser    // status[2:0]
);

    cfg_t        cfg_reg;
    logic        m_valid_reg;
    logic [31:0] m_addr_reg;
    logic [2:0]  m_status_reg;
    logic        res_valid;
    logic        res_ready;
    res_t        res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_BASE_PAGE:   cfg_reg.base_page        <= cfg_data;
                REG_PAGE_COUNT:  cfg_reg.page_count       <= cfg_data[15:0];
                REG_UPPER_START: cfg_reg.upper_start_word <= cfg_data[10:0];
                default:
                begin
                end
            endcase
        end
    end

    pfba_ctrl #(
        .MAX_PAGES (MAX_PAGES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .req_valid (s_axis_tvalid),
        .req_ready (s_axis_tready),
        .req_func  (s_axis_tuser),
        .req_addr  (s_axis_tdata),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // output word register
    assign res_ready = !m_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            m_addr_reg   <= res.page_addr;
            m_status_reg <= res.status;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_addr_reg;
    assign m_axis_tuser  = m_status_reg;

endmodule

`default_nettype wire
